[rtl/wsfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the word-stuffed frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int WORD_W      = 32;
    localparam int KIND_W      = 2;
    localparam int VBYTES_W    = 3;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int FILL_W      = 2;

    localparam logic [WORD_W-1:0]   BYTES_INIT       = 32'd4;
    localparam logic [WORD_W:0]     WORD_BYTES_EXT   = 33'd4;
    localparam logic [VBYTES_W-1:0] WORD_BYTES_VB    = 3'd4;
    localparam logic [WORD_W-1:0]   DELIM_FIRST_RST  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]   DELIM_SECOND_RST = 32'hFFFF_FFFE;
    localparam logic [WORD_W-1:0]   PADDING_RST      = 32'hFFFF_FFFD;
    localparam logic [WORD_W-1:0]   MAX_BYTES_RST    = 32'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD  = 2'd0,
        KIND_TRUNC = 2'd1,
        KIND_END   = 2'd2
    } kind_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA     = 3'd0,
        ST_DONE     = 3'd1,
        ST_NO_DELIM = 3'd2,
        ST_NO_PAD   = 3'd3,
        ST_PAD_ONLY = 3'd4,
        ST_LIMIT    = 3'd5,
        ST_TRUNC    = 3'd6,
        ST_PAD_OVER = 3'd7
    } status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_FIRST  = 2'd0,
        REG_DELIM_SECOND = 2'd1,
        REG_PADDING      = 2'd2,
        REG_MAX_BYTES    = 2'd3
    } reg_idx_e;

    typedef struct packed {
        logic [WORD_W-1:0] delimiter_first;
        logic [WORD_W-1:0] delimiter_second;
        logic [WORD_W-1:0] padding_word;
        logic [WORD_W-1:0] max_bytes;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]   data_word;
        logic [VBYTES_W-1:0] valid_bytes;
        status_e             status;
        logic                last;
    } res_t;

endpackage

[rtl/wsfd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd channel interfaces
// Valid/ready channels for stream words in and decoded results out.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
    import wsfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   word;

    modport source (output valid, output kind, output word, input ready);
    modport sink   (input valid, input kind, input word, output ready);
endinterface

interface wsfd_out_if;
    import wsfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [WORD_W-1:0]     data_word;
    logic [VBYTES_W-1:0]   valid_bytes;
    logic [STATUS_W-1:0]   status;
    logic                  last;

    modport source (output valid, output data_word, output valid_bytes, output status,
                    output last, input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input status,
                    input last, output ready);
endinterface

[rtl/wsfd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module wsfd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [wsfd_pkg::CFG_IDX_W-1:0]   index,
    input  logic [wsfd_pkg::WORD_W-1:0]      data,
    output wsfd_pkg::cfg_t                   cfg
);
    import wsfd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_first  <= DELIM_FIRST_RST;
            cfg_reg.delimiter_second <= DELIM_SECOND_RST;
            cfg_reg.padding_word     <= PADDING_RST;
            cfg_reg.max_bytes        <= MAX_BYTES_RST;
        end
        else if (we)
        begin
            unique case (reg_idx_e'(index))
                REG_DELIM_FIRST:  cfg_reg.delimiter_first  <= data;
                REG_DELIM_SECOND: cfg_reg.delimiter_second <= data;
                REG_PADDING:      cfg_reg.padding_word     <= data;
                REG_MAX_BYTES:    cfg_reg.max_bytes        <= data;
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/wsfd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_core
// Window state, padding removal, delimiter, pad count and byte limit checks,
// one word per cycle while the result queue has space.
// ----------------------------------------------------------------------------
module wsfd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wsfd_pkg::cfg_t       cfg,
    wsfd_in_if.sink              words,
    input  logic                 space,
    output logic                 push,
    output wsfd_pkg::res_t       res
);
    import wsfd_pkg::*;

    // window entries 0..2; a fourth word is only ever the incoming one
    logic [WORD_W-1:0] w_reg [3];
    logic [WORD_W-1:0] w_next [3];
    logic [WORD_W-1:0] last_reg, last_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              after_reg, after_next;
    logic [WORD_W-1:0] bytes_reg, bytes_next;

    logic              take;
    logic [WORD_W:0]   bytes_sum;
    logic [WORD_W-1:0] bytes_inc;
    logic              over_limit;
    logic              is_delim;
    logic              is_pad;
    logic [WORD_W-1:0] pad;

    assign words.ready = space;
    assign take        = words.valid && space;

    assign bytes_sum  = {1'b0, bytes_reg} + WORD_BYTES_EXT;
    assign bytes_inc  = bytes_sum[WORD_W] ? '1 : bytes_sum[WORD_W-1:0];
    assign over_limit = (cfg.max_bytes != '0) && (bytes_inc > cfg.max_bytes);
    assign is_delim   = (fill_reg != '0) && !after_reg &&
                        (words.word == cfg.delimiter_first) &&
                        (last_reg == cfg.delimiter_second);
    assign is_pad     = (fill_reg != '0) && !after_reg && (words.word == cfg.padding_word);
    assign pad        = (fill_reg == 2'd3) ? w_reg[1] : w_reg[0];

    always_comb
    begin
        w_next     = w_reg;
        last_next  = last_reg;
        fill_next  = fill_reg;
        after_next = after_reg;
        bytes_next = bytes_reg;
        push       = 1'b0;
        res        = '{data_word: '0, valid_bytes: '0, status: ST_DATA, last: 1'b0};

        if (take)
        begin
            case (kind_e'(words.kind))
                KIND_WORD:
                begin
                    if (over_limit)
                    begin
                        push       = 1'b1;
                        res.status = ST_LIMIT;
                        res.last   = 1'b1;
                    end
                    else if (is_delim)
                    begin
                        push     = 1'b1;
                        res.last = 1'b1;
                        case (fill_reg) inside
                            2'd0, 2'd1: res.status = ST_NO_PAD;
                            2'd2:
                            begin
                                if (pad == '0)
                                    res.status = ST_DONE;
                                else if (pad[WORD_W-1:2] != '0)
                                    res.status = ST_PAD_OVER;
                                else
                                    res.status = ST_PAD_ONLY;
                            end
                            default:
                            begin
                                if (pad[WORD_W-1:2] != '0)
                                    res.status = ST_PAD_OVER;
                                else
                                begin
                                    res.status      = ST_DATA;
                                    res.data_word   = w_reg[0];
                                    res.valid_bytes = WORD_BYTES_VB - {1'b0, pad[1:0]};
                                end
                            end
                        endcase
                    end
                    else if (is_pad)
                    begin
                        // first padding word of a run is dropped
                        after_next = 1'b1;
                        bytes_next = bytes_inc;
                    end
                    else
                    begin
                        after_next = 1'b0;
                        bytes_next = bytes_inc;
                        last_next  = words.word;
                        case (fill_reg)
                            2'd0:
                            begin
                                w_next[0] = words.word;
                                fill_next = 2'd1;
                            end
                            2'd1:
                            begin
                                w_next[1] = words.word;
                                fill_next = 2'd2;
                            end
                            2'd2:
                            begin
                                w_next[2] = words.word;
                                fill_next = 2'd3;
                            end
                            default:
                            begin
                                // window full: oldest word leaves as data
                                w_next[0]       = w_reg[1];
                                w_next[1]       = w_reg[2];
                                w_next[2]       = words.word;
                                push            = 1'b1;
                                res.data_word   = w_reg[0];
                                res.valid_bytes = WORD_BYTES_VB;
                            end
                        endcase
                    end
                end
                KIND_TRUNC:
                begin
                    push       = 1'b1;
                    res.status = ST_TRUNC;
                    res.last   = 1'b1;
                end
                default:
                begin
                    push       = 1'b1;
                    res.status = ST_NO_DELIM;
                    res.last   = 1'b1;
                end
            endcase

            if (res.last)
            begin
                fill_next  = '0;
                after_next = 1'b0;
                bytes_next = BYTES_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            after_reg <= 1'b0;
            bytes_reg <= BYTES_INIT;
        end
        else
        begin
            fill_reg  <= fill_next;
            after_reg <= after_next;
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        last_reg <= last_next;
    end

    a_push_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed with no queue space");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.last |=> fill_reg == '0 && !after_reg && bytes_reg == BYTES_INIT)
        else $error("terminal result did not clear frame state");

    a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        take && words.kind == KIND_TRUNC |-> push && res.status == ST_TRUNC && res.last)
        else $error("truncated word did not end the frame");

    a_after_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        after_reg |-> fill_reg != '0)
        else $error("padding flag set with empty window");

    a_bytes_floor: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg >= BYTES_INIT)
        else $error("byte count below codec id size");

endmodule

[rtl/wsfd_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_outq
// Two-entry result queue; decouples input acceptance from output stalls.
// ----------------------------------------------------------------------------
module wsfd_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wsfd_pkg::res_t   din,
    output logic             space,
    wsfd_out_if.source       results
);
    import wsfd_pkg::*;

    res_t       q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;
    res_t       head;

    assign pop   = (count_reg != 2'd0) && results.ready;
    assign space = (count_reg != 2'd2);
    assign head  = q_reg[rd_reg];

    assign results.valid       = (count_reg != 2'd0);
    assign results.data_word   = head.data_word;
    assign results.valid_bytes = head.valid_bytes;
    assign results.status      = head.status;
    assign results.last        = head.last;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= din;
    end

endmodule

[rtl/word_stuffing_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stuffing_frame_decoder
// Removes word stuffing and delimiter framing from a 32-bit word stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  words     in   valid/ready   kind[1:0], word[31:0]
//  results   out  valid/ready   data_word[31:0], valid_bytes[2:0], status[2:0], last
//  cfg       in   cfg_we        cfg_index[1:0], cfg_data[31:0]
//
//  one word per cycle while a queue entry is free; any result is queued on acceptance
//  results wait in a two-entry queue, so words keep flowing while one result stalls
//  words.ready drops only when both queue entries are full
//  rst_n clears frame state and restores register defaults; no clearing pass
// ----------------------------------------------------------------------------
module word_stuffing_frame_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsfd_pkg::WORD_W-1:0]      cfg_data,
    wsfd_in_if.sink                          words,
    wsfd_out_if.source                       results
);
    import wsfd_pkg::*;

    cfg_t cfg;
    res_t res;
    logic push;
    logic space;

    wsfd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    wsfd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .words (words),
        .space (space),
        .push  (push),
        .res   (res)
    );

    wsfd_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .din     (res),
        .space   (space),
        .results (results)
    );

endmodule

[dv/tb_word_stuffing_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_stuffing_frame_decoder
// Feeds framed and broken word streams through the deframer under several
// register settings and handshake pressure, predicts every result with an
// in-bench decoder and checks each result field in order.
// ----------------------------------------------------------------------------
module tb_word_stuffing_frame_decoder;
    import wsfd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
    } word_item_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    wsfd_in_if  word_ch ();
    wsfd_out_if res_ch ();

    word_stuffing_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .words     (word_ch),
        .results   (res_ch)
    );

    // decoder state and register copy
    logic [WORD_W-1:0] frame_win [4];
    logic [2:0]        win_fill;
    logic              pad_seen;
    logic [WORD_W-1:0] bytes_in;
    cfg_t              regs;

    word_item_t pending [$];
    res_t       expected_results [$];
    int         n_issued;
    int         n_accepted;
    int         mismatches;
    int         quiet;
    int         src_idle;
    int         snk_stall;
    int         calm_left;
    logic       in_taken;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_frame();
        for (int i = 0; i < 4; i++)
            frame_win[i] = '0;
        win_fill = '0;
        pad_seen = 1'b0;
        bytes_in = BYTES_INIT;
    endfunction

    function automatic res_t make_result(logic [WORD_W-1:0] d, logic [VBYTES_W-1:0] vb,
                                         status_e st, logic lst);
        res_t r;
        r.data_word   = d;
        r.valid_bytes = vb;
        r.status      = st;
        r.last        = lst;
        if (lst)
            clear_frame();
        return r;
    endfunction

    // returns 1 when the word produces a result
    function automatic bit decode_word(input logic [KIND_W-1:0] kind,
                                       input logic [WORD_W-1:0] w, output res_t r);
        int n;
        r = '0;
        if (kind == KIND_TRUNC)
        begin
            r = make_result('0, '0, ST_TRUNC, 1'b1);
            return 1;
        end
        if (kind != KIND_WORD)
        begin
            r = make_result('0, '0, ST_NO_DELIM, 1'b1);
            return 1;
        end
        bytes_in = (bytes_in > 32'hFFFF_FFFB) ? 32'hFFFF_FFFF : bytes_in + BYTES_INIT;
        if (regs.max_bytes != 0 && bytes_in > regs.max_bytes)
        begin
            r = make_result('0, '0, ST_LIMIT, 1'b1);
            return 1;
        end
        if (win_fill >= 3'd4)
            win_fill = 3'd3;
        frame_win[win_fill[1:0]] = w;
        win_fill++;
        n = int'(win_fill);
        if (n == 1)
            return 0;
        if (frame_win[n-1] == regs.delimiter_first && frame_win[n-2] == regs.delimiter_second
            && !pad_seen)
        begin
            if (n < 3)
                r = make_result('0, '0, ST_NO_PAD, 1'b1);
            else if (n == 3)
            begin
                if (frame_win[0] == 0)
                    r = make_result('0, '0, ST_DONE, 1'b1);
                else if (frame_win[0] > 3)
                    r = make_result('0, '0, ST_PAD_OVER, 1'b1);
                else
                    r = make_result('0, '0, ST_PAD_ONLY, 1'b1);
            end
            else if (frame_win[1] > 3)
                r = make_result('0, '0, ST_PAD_OVER, 1'b1);
            else
                r = make_result(frame_win[0], WORD_BYTES_VB - frame_win[1][2:0], ST_DATA, 1'b1);
            return 1;
        end
        // first padding word of a run is dropped
        if (w == regs.padding_word && !pad_seen)
        begin
            pad_seen = 1'b1;
            win_fill = 3'(n - 1);
            return 0;
        end
        pad_seen = 1'b0;
        if (n == 4)
        begin
            r = make_result(frame_win[0], WORD_BYTES_VB, ST_DATA, 1'b0);
            frame_win[0] = frame_win[1];
            frame_win[1] = frame_win[2];
            frame_win[2] = frame_win[3];
            frame_win[3] = '0;
            win_fill = 3'd3;
            return 1;
        end
        return 0;
    endfunction

    always @(negedge clk)
    begin : driver
        word_item_t nxt;
        if (rst_n)
        begin
            if (calm_left != 0)
                calm_left--;
            else if ($urandom_range(99) < 2)
                calm_left = $urandom_range(40, 10);
            if (!word_ch.valid || in_taken)
            begin
                if (pending.size() != 0 && (calm_left != 0 || $urandom_range(99) >= src_idle))
                begin
                    nxt = pending.pop_front();
                    word_ch.valid <= 1'b1;
                    word_ch.kind  <= nxt.kind;
                    word_ch.word  <= nxt.word;
                end
                else
                begin
                    word_ch.valid <= 1'b0;
                end
            end
            res_ch.ready <= (calm_left != 0) || ($urandom_range(99) >= snk_stall);
        end
    end

    always @(posedge clk)
    begin : monitor
        res_t want;
        bit   fires;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= word_ch.valid && word_ch.ready;
            if (word_ch.valid && word_ch.ready)
            begin
                fires = decode_word(word_ch.kind, word_ch.word, want);
                if (fires)
                    expected_results.push_back(want);
                n_accepted++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: data=%h bytes=%0d status=%0d last=%0d",
                                 res_ch.data_word, res_ch.valid_bytes, res_ch.status,
                                 res_ch.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.data_word !== res_ch.data_word
                        || want.valid_bytes !== res_ch.valid_bytes
                        || want.status !== res_ch.status || want.last !== res_ch.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: exp data=%h bytes=%0d status=%0d last=%0d",
                                     want.data_word, want.valid_bytes, want.status, want.last);
                            $display("                 got data=%h bytes=%0d status=%0d last=%0d",
                                     res_ch.data_word, res_ch.valid_bytes, res_ch.status,
                                     res_ch.last);
                        end
                    end
                end
            end
            if ((word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] w);
        word_item_t it;
        it.kind = kind;
        it.word = w;
        pending.push_back(it);
        n_issued++;
    endtask

    // escape words the decoder would otherwise drop or take as a delimiter
    task automatic add_stuffed(logic [WORD_W-1:0] w);
        if (w == regs.padding_word || w == regs.delimiter_first)
            add_item(KIND_WORD, regs.padding_word);
        add_item(KIND_WORD, w);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return regs.padding_word;
            1: return regs.delimiter_first;
            2: return regs.delimiter_second;
            3: return 32'h0;
            4: return 32'hFFFF_FFFF;
            5: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_frame();
        int                pick;
        int                nd;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] cnt;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            // noise, some of it with odd kinds
            nd = $urandom_range(6, 1);
            for (int i = 0; i < nd; i++)
            begin
                kind = KIND_WORD;
                if ($urandom_range(9) == 0)
                    kind = KIND_W'($urandom_range(3));
                add_item(kind, $urandom);
            end
            return;
        end
        nd = ($urandom_range(4) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 0);
        for (int i = 0; i < nd; i++)
            add_stuffed(pick_word());
        if (pick < 22)
        begin
            // frame cut short by a truncated read, end of input or an unused kind
            kind = KIND_W'($urandom_range(3, 1));
            add_item(kind, $urandom);
            return;
        end
        if (pick < 30)
            cnt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(12, 4);
        else if (nd == 0)
            cnt = ($urandom_range(5) == 0) ? $urandom_range(3, 1) : 0;
        else
            cnt = $urandom_range(3);
        // occasionally leave the pad count out
        if (pick >= 34)
            add_stuffed(cnt);
        add_item(KIND_WORD, regs.delimiter_second);
        add_item(KIND_WORD, regs.delimiter_first);
    endtask

    task automatic write_reg(reg_idx_e idx, logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELIM_FIRST:  regs.delimiter_first  = val;
            REG_DELIM_SECOND: regs.delimiter_second = val;
            REG_PADDING:      regs.padding_word     = val;
            REG_MAX_BYTES:    regs.max_bytes        = val;
        endcase
    endtask

    task automatic load_regs(logic [WORD_W-1:0] first, logic [WORD_W-1:0] second,
                             logic [WORD_W-1:0] pad, logic [WORD_W-1:0] limit);
        write_reg(REG_DELIM_FIRST, first);
        write_reg(REG_DELIM_SECOND, second);
        write_reg(REG_PADDING, pad);
        write_reg(REG_MAX_BYTES, limit);
    endtask

    function automatic logic [WORD_W-1:0] any_reg_value();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] any_limit();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(120, 8);
        endcase
    endfunction

    // block is idle once every word is taken and every result is back
    task automatic wait_quiet();
        while (n_accepted != n_issued || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int src, int snk, int count);
        int target;
        src_idle  = src;
        snk_stall = snk;
        target    = n_issued + count;
        while (n_issued < target)
            add_frame();
        wait_quiet();
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DELIM_FIRST;
        cfg_data      = '0;
        word_ch.valid = 1'b0;
        word_ch.kind  = KIND_WORD;
        word_ch.word  = '0;
        res_ch.ready  = 1'b0;
        in_taken      = 1'b0;
        n_issued      = 0;
        n_accepted    = 0;
        mismatches    = 0;
        quiet         = 0;
        src_idle      = 0;
        snk_stall     = 0;
        calm_left     = 0;
        regs.delimiter_first  = DELIM_FIRST_RST;
        regs.delimiter_second = DELIM_SECOND_RST;
        regs.padding_word     = PADDING_RST;
        regs.max_bytes        = MAX_BYTES_RST;
        clear_frame();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed, with register defaults
        add_item(KIND_TRUNC, 32'hA5A5_5A5A);
        add_item(KIND_END, 32'h0);
        add_item(KIND_UNUSED, 32'hFFFF_FFFF);
        // empty frame
        add_item(KIND_WORD, 32'h0);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        // delimiter with no pad count
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        // pad count without data
        add_item(KIND_WORD, 32'd2);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        // stuffed padding word in the data, three bytes in the last word
        add_item(KIND_WORD, 32'h1122_3344);
        add_item(KIND_WORD, PADDING_RST);
        add_item(KIND_WORD, PADDING_RST);
        add_item(KIND_WORD, 32'd1);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        // padding hides a delimiter pair inside the data
        add_item(KIND_WORD, 32'h0);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, PADDING_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        add_item(KIND_WORD, 32'h0);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);
        // pad count over 3 with data
        add_item(KIND_WORD, 32'hDEAD_BEEF);
        add_item(KIND_WORD, 32'd7);
        add_item(KIND_WORD, DELIM_SECOND_RST);
        add_item(KIND_WORD, DELIM_FIRST_RST);

        run_phase(0, 0, 250);
        load_regs(32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'd40);
        run_phase(67, 0, 300);
        load_regs(32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(0, 67, 300);
        load_regs(32'd3, 32'd2, 32'd0, 32'd4);
        run_phase(19, 19, 60);
        load_regs(any_reg_value(), any_reg_value(), any_reg_value(), any_limit());
        run_phase(19, 19, 350);
        load_regs(any_reg_value(), any_reg_value(), any_reg_value(), any_limit());
        run_phase(67, 0, 350);

        repeat (16) @(negedge clk);
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/wsfd_pkg.sv
rtl/wsfd_if.sv
rtl/wsfd_cfg.sv
rtl/wsfd_core.sv
rtl/wsfd_outq.sv
rtl/word_stuffing_frame_decoder.sv
dv/tb_word_stuffing_frame_decoder.sv
